// ----- sv/piob_pkg.sv -----
// shared types, constants and helper functions of the price indexed order book
package piob_pkg;

    localparam int LVL_W       = 16;
    localparam int LEVEL_COUNT = 1 << LVL_W;
    localparam int SLOT_W      = 16;
    localparam int ORDER_SLOTS = 1 << SLOT_W;
    localparam int FILL_W      = SLOT_W + 1;
    localparam int HI_W        = 8;
    localparam int LO_W        = LVL_W - HI_W;
    localparam int OCC_WORDS   = 1 << HI_W;
    localparam int OCC_BITS    = 1 << LO_W;

    localparam int ID_W    = 64;
    localparam int QTY_IN_W = 32;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 40;
    localparam int CNT_W   = 17;
    localparam int CMD_W   = 2;
    localparam int ST_W    = 3;

    localparam int IN_FIELDS_W = 2 * ID_W + 1 + QTY_IN_W + PRICE_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 2 * PRICE_W;

    localparam logic [QTY_W-1:0] QTY_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXECUTE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE    = 3'd0;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd1;
    localparam logic [ST_W-1:0] ST_DUP     = 3'd2;
    localparam logic [ST_W-1:0] ST_RANGE   = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;

    localparam logic [1:0] ACT_KEEP = 2'd0;
    localparam logic [1:0] ACT_SET  = 2'd1;
    localparam logic [1:0] ACT_CLRZ = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [ID_W-1:0]     id;
        logic [ID_W-1:0]     new_id;
        logic                side;
        logic [QTY_IN_W-1:0] qty;
        logic [PRICE_W-1:0]  price;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0]     key;
        logic                is_bid;
        logic [LVL_W-1:0]    level;
        logic [QTY_IN_W-1:0] rem;
    } t_slot;

    typedef struct packed {
        logic [QTY_W-1:0] qty;
        logic [CNT_W-1:0] cnt;
        logic             act;
    } t_level;

    typedef struct packed {
        logic                side;
        logic [LVL_W-1:0]    idx;
        logic [QTY_IN_W-1:0] sub;
        logic [QTY_IN_W-1:0] add;
        logic [1:0]          cnt_op;
        logic [1:0]          act_op;
    } t_lvop;

    typedef struct packed {
        logic clr;
        logic load;
        logic scan;
        logic decide;
        logic lv_rd;
        logic lv_sub;
        logic lv_wr;
        logic mv_rd;
        logic mv_wr;
        logic srch;
        logic srd;
        logic senc;
        logic sout;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic op_pend;
        logic del_pend;
    } t_sts;

    function automatic logic [HI_W-1:0] f_sum_hi(input logic [OCC_WORDS-1:0] v);
        logic [HI_W-1:0] r;
        r = '0;
        for (int i = 0; i < OCC_WORDS; i++) begin
            if (v[i]) r = HI_W'(i);
        end
        return r;
    endfunction

    function automatic logic [HI_W-1:0] f_sum_lo(input logic [OCC_WORDS-1:0] v);
        logic [HI_W-1:0] r;
        r = '0;
        for (int i = OCC_WORDS - 1; i >= 0; i--) begin
            if (v[i]) r = HI_W'(i);
        end
        return r;
    endfunction

    function automatic logic [LO_W-1:0] f_word_hi(input logic [OCC_BITS-1:0] v);
        logic [LO_W-1:0] r;
        r = '0;
        for (int i = 0; i < OCC_BITS; i++) begin
            if (v[i]) r = LO_W'(i);
        end
        return r;
    endfunction

    function automatic logic [LO_W-1:0] f_word_lo(input logic [OCC_BITS-1:0] v);
        logic [LO_W-1:0] r;
        r = '0;
        for (int i = OCC_BITS - 1; i >= 0; i--) begin
            if (v[i]) r = LO_W'(i);
        end
        return r;
    endfunction

endpackage

// ----- sv/piob_ctrl.sv -----
// command sequencer of the order book
module piob_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    input  piob_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output piob_pkg::t_cmd  o_cmd
);
    import piob_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_DEC  = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_LRD  = 4'd5;
    localparam logic [3:0] S_LSUB = 4'd6;
    localparam logic [3:0] S_LWR  = 4'd7;
    localparam logic [3:0] S_MRD  = 4'd8;
    localparam logic [3:0] S_MWR  = 4'd9;
    localparam logic [3:0] S_SRCH = 4'd10;
    localparam logic [3:0] S_SRD  = 4'd11;
    localparam logic [3:0] S_SENC = 4'd12;
    localparam logic [3:0] S_SOUT = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_cmd       w_cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_out_ready;
        w_cmd       = '0;
        case (r_state)
            S_CLR: begin
                w_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                w_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = S_DEC;
            end
            S_DEC: begin
                w_cmd.decide = 1'b1;
                n_state      = S_CHK;
            end
            S_CHK: begin
                if (i_sts.op_pend) n_state = S_LRD;
                else if (i_sts.del_pend) n_state = S_MRD;
                else n_state = S_SRCH;
            end
            S_LRD: begin
                w_cmd.lv_rd = 1'b1;
                n_state     = S_LSUB;
            end
            S_LSUB: begin
                w_cmd.lv_sub = 1'b1;
                n_state      = S_LWR;
            end
            S_LWR: begin
                w_cmd.lv_wr = 1'b1;
                n_state     = S_CHK;
            end
            S_MRD: begin
                w_cmd.mv_rd = 1'b1;
                n_state     = S_MWR;
            end
            S_MWR: begin
                w_cmd.mv_wr = 1'b1;
                n_state     = S_SRCH;
            end
            S_SRCH: begin
                w_cmd.srch = 1'b1;
                n_state    = S_SRD;
            end
            S_SRD: begin
                w_cmd.srd = 1'b1;
                n_state   = S_SENC;
            end
            S_SENC: begin
                w_cmd.senc = 1'b1;
                n_state    = S_SOUT;
            end
            S_SOUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.sout  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

// ----- sv/piob_dp.sv -----
// order table, price level arrays, occupancy maps and best price search
module piob_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  piob_pkg::t_cmd                i_cmd,
    input  piob_pkg::t_item               i_item,
    input  logic                          i_cfg_wr_en,
    input  logic [piob_pkg::PRICE_W-1:0]  i_cfg_wr_data,
    output piob_pkg::t_sts                o_sts,
    output logic [piob_pkg::ST_W-1:0]     o_status,
    output logic [piob_pkg::PRICE_W-1:0]  o_best_bid,
    output logic [piob_pkg::PRICE_W-1:0]  o_best_ask
);
    import piob_pkg::*;

    logic [PRICE_W-1:0] r_base_price;
    t_item              r_item;

    // order table
    t_slot              mem_slot [ORDER_SLOTS];
    t_slot              r_slot_rd;
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  r_scan;
    logic [SLOT_W-1:0]  r_rd_addr;
    logic               r_rd_pend;
    logic               r_found, r_ofound;
    logic [SLOT_W-1:0]  r_s, r_o;
    t_slot              r_ent;

    // level bookkeeping
    t_level             mem_bid_lv [LEVEL_COUNT];
    t_level             mem_ask_lv [LEVEL_COUNT];
    t_level             r_blv_rd, r_alv_rd;
    logic [QTY_W-1:0]   r_qsub;
    t_lvop              r_op, r_op2;
    logic               r_op_pend, r_op2_pend, r_del_pend;
    logic [LVL_W-1:0]   r_clr;
    logic               r_clr_done;

    // occupancy maps
    logic [OCC_BITS-1:0]  mem_bid_occ [OCC_WORDS];
    logic [OCC_BITS-1:0]  mem_ask_occ [OCC_WORDS];
    logic [OCC_BITS-1:0]  r_bocc_rd, r_aocc_rd;
    logic [OCC_WORDS-1:0] r_bsum, r_asum;

    // search
    logic [HI_W-1:0]    r_bhi, r_ahi;
    logic [LO_W-1:0]    r_blo, r_alo;
    logic               r_bany, r_aany;

    logic [ST_W-1:0]    r_status;
    logic [ST_W-1:0]    r_out_status;
    logic [PRICE_W-1:0] r_out_bid, r_out_ask;

    // decision
    logic [PRICE_W:0]    w_diff;
    logic                w_in_rng;
    logic [LVL_W-1:0]    w_lvl;
    logic [QTY_IN_W-1:0] w_take, w_left;
    logic [ST_W-1:0]     d_status;
    t_lvop               d_op, d_op2;
    logic                d_op_pend, d_op2_pend, d_del, d_fill_inc;

    // order table port
    logic                slot_we, slot_re;
    logic [SLOT_W-1:0]   slot_wa, slot_ra;
    t_slot               slot_wd;
    logic [FILL_W-1:0]   w_last;
    logic                w_scan_go;

    // level write back
    t_level              w_lv, w_lv_new;
    logic [QTY_W:0]      w_sum;
    logic                w_occ;
    logic [HI_W-1:0]     w_hi;
    logic [LO_W-1:0]     w_lo;
    logic [OCC_BITS-1:0] w_word;
    logic [HI_W-1:0]     w_bocc_ra, w_aocc_ra;
    logic                w_occ_re;

    assign w_diff   = {1'b0, r_item.price} - {1'b0, r_base_price};
    assign w_in_rng = !w_diff[PRICE_W] && (w_diff[PRICE_W-1:LVL_W] == '0);
    assign w_lvl    = w_diff[LVL_W-1:0];
    assign w_take   = (r_item.qty < r_ent.rem) ? r_item.qty : r_ent.rem;
    assign w_left   = r_ent.rem - w_take;
    assign w_last   = r_fill - FILL_W'(1);
    assign w_scan_go = i_cmd.scan && (r_scan != r_fill);

    always_comb begin
        d_status   = ST_DONE;
        d_op       = '0;
        d_op2      = '0;
        d_op_pend  = 1'b0;
        d_op2_pend = 1'b0;
        d_del      = 1'b0;
        d_fill_inc = 1'b0;
        slot_we    = 1'b0;
        slot_wa    = r_s;
        slot_wd    = r_ent;
        if (i_cmd.decide) begin
            if (r_item.cmd == CMD_ADD) begin
                if (r_found) begin
                    d_status = ST_DUP;
                end else if (!w_in_rng) begin
                    d_status = ST_RANGE;
                end else if (r_fill == FILL_W'(ORDER_SLOTS)) begin
                    d_status = ST_FULL;
                end else begin
                    slot_we    = 1'b1;
                    slot_wa    = r_fill[SLOT_W-1:0];
                    slot_wd    = '{key: r_item.id, is_bid: r_item.side, level: w_lvl,
                                   rem: r_item.qty};
                    d_fill_inc = 1'b1;
                    d_op       = '{side: r_item.side, idx: w_lvl, sub: '0, add: r_item.qty,
                                   cnt_op: CNT_INC, act_op: ACT_SET};
                    d_op_pend  = 1'b1;
                end
            end else if (!r_found) begin
                d_status = ST_UNKNOWN;
            end else if (r_item.cmd == CMD_EXECUTE) begin
                d_op_pend = 1'b1;
                if (w_left == '0) begin
                    d_op  = '{side: r_ent.is_bid, idx: r_ent.level, sub: w_take, add: '0,
                              cnt_op: CNT_DEC, act_op: ACT_CLRZ};
                    d_del = 1'b1;
                end else begin
                    d_op        = '{side: r_ent.is_bid, idx: r_ent.level, sub: w_take,
                                    add: '0, cnt_op: CNT_NONE, act_op: ACT_KEEP};
                    slot_we     = 1'b1;
                    slot_wd.rem = w_left;
                end
            end else if (r_item.cmd == CMD_DELETE) begin
                d_op      = '{side: r_ent.is_bid, idx: r_ent.level, sub: r_ent.rem, add: '0,
                              cnt_op: CNT_DEC, act_op: ACT_CLRZ};
                d_op_pend = 1'b1;
                d_del     = 1'b1;
            end else begin
                if (r_ofound && (r_o != r_s)) begin
                    d_status = ST_DUP;
                end else if (!w_in_rng) begin
                    d_status = ST_RANGE;
                end else begin
                    slot_we   = 1'b1;
                    slot_wd   = '{key: r_item.new_id, is_bid: r_ent.is_bid, level: w_lvl,
                                  rem: r_item.qty};
                    d_op_pend = 1'b1;
                    if (w_lvl != r_ent.level) begin
                        d_op       = '{side: r_ent.is_bid, idx: r_ent.level, sub: r_ent.rem,
                                       add: '0, cnt_op: CNT_DEC, act_op: ACT_CLRZ};
                        d_op2      = '{side: r_ent.is_bid, idx: w_lvl, sub: '0,
                                       add: r_item.qty, cnt_op: CNT_INC, act_op: ACT_SET};
                        d_op2_pend = 1'b1;
                    end else begin
                        d_op = '{side: r_ent.is_bid, idx: w_lvl, sub: r_ent.rem,
                                 add: r_item.qty, cnt_op: CNT_NONE, act_op: ACT_KEEP};
                    end
                end
            end
        end else if (i_cmd.mv_wr) begin
            slot_we = 1'b1;
            slot_wa = r_s;
            slot_wd = r_slot_rd;
        end
    end

    assign slot_re = w_scan_go || i_cmd.mv_rd;
    assign slot_ra = i_cmd.mv_rd ? w_last[SLOT_W-1:0] : r_scan[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (slot_we) mem_slot[slot_wa] <= slot_wd;
        if (slot_re) r_slot_rd <= mem_slot[slot_ra];
    end

    // level write back
    assign w_lv  = r_op.side ? r_blv_rd : r_alv_rd;
    assign w_sum = {1'b0, r_qsub} + (QTY_W + 1)'(r_op.add);
    assign w_hi  = r_op.idx[LVL_W-1:LO_W];
    assign w_lo  = r_op.idx[LO_W-1:0];

    always_comb begin
        w_lv_new     = w_lv;
        w_lv_new.qty = w_sum[QTY_W] ? QTY_MAX : w_sum[QTY_W-1:0];
        case (r_op.cnt_op)
            CNT_INC: if (w_lv.cnt != CNT_MAX) w_lv_new.cnt = w_lv.cnt + CNT_W'(1);
            CNT_DEC: if (w_lv.cnt != '0) w_lv_new.cnt = w_lv.cnt - CNT_W'(1);
            default: w_lv_new.cnt = w_lv.cnt;
        endcase
        case (r_op.act_op)
            ACT_SET:  w_lv_new.act = 1'b1;
            ACT_CLRZ: if (w_lv_new.qty == '0) w_lv_new.act = 1'b0;
            default:  w_lv_new.act = w_lv.act;
        endcase
        w_occ = w_lv_new.act && (w_lv_new.qty != '0);
        if (r_op.side) w_word = r_bsum[w_hi] ? r_bocc_rd : '0;
        else w_word = r_asum[w_hi] ? r_aocc_rd : '0;
        w_word[w_lo] = w_occ;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr && !r_clr_done) mem_bid_lv[r_clr] <= '0;
        else if (i_cmd.lv_wr && r_op.side) mem_bid_lv[r_op.idx] <= w_lv_new;
        if (i_cmd.lv_rd) r_blv_rd <= mem_bid_lv[r_op.idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr && !r_clr_done) mem_ask_lv[r_clr] <= '0;
        else if (i_cmd.lv_wr && !r_op.side) mem_ask_lv[r_op.idx] <= w_lv_new;
        if (i_cmd.lv_rd) r_alv_rd <= mem_ask_lv[r_op.idx];
    end

    assign w_occ_re  = i_cmd.lv_rd || i_cmd.srd;
    assign w_bocc_ra = i_cmd.srd ? r_bhi : r_op.idx[LVL_W-1:LO_W];
    assign w_aocc_ra = i_cmd.srd ? r_ahi : r_op.idx[LVL_W-1:LO_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.lv_wr && r_op.side) mem_bid_occ[w_hi] <= w_word;
        if (w_occ_re) r_bocc_rd <= mem_bid_occ[w_bocc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lv_wr && !r_op.side) mem_ask_occ[w_hi] <= w_word;
        if (w_occ_re) r_aocc_rd <= mem_ask_occ[w_aocc_ra];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_price <= '0;
            r_fill       <= '0;
            r_scan       <= '0;
            r_rd_pend    <= 1'b0;
            r_found      <= 1'b0;
            r_ofound     <= 1'b0;
            r_op_pend    <= 1'b0;
            r_op2_pend   <= 1'b0;
            r_del_pend   <= 1'b0;
            r_clr        <= '0;
            r_clr_done   <= 1'b0;
            r_bsum       <= '0;
            r_asum       <= '0;
        end else begin
            if (i_cfg_wr_en) r_base_price <= i_cfg_wr_data;
            if (i_cmd.clr && !r_clr_done) begin
                r_clr <= r_clr + LVL_W'(1);
                if (r_clr == LVL_W'(LEVEL_COUNT - 1)) r_clr_done <= 1'b1;
            end
            if (i_cmd.load) begin
                r_scan     <= '0;
                r_rd_pend  <= 1'b0;
                r_found    <= 1'b0;
                r_ofound   <= 1'b0;
                r_op_pend  <= 1'b0;
                r_op2_pend <= 1'b0;
                r_del_pend <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_rd_pend <= w_scan_go;
                if (w_scan_go) r_scan <= r_scan + FILL_W'(1);
                if (r_rd_pend && r_slot_rd.key == r_item.id) r_found <= 1'b1;
                if (r_rd_pend && r_slot_rd.key == r_item.new_id) r_ofound <= 1'b1;
            end
            if (i_cmd.decide) begin
                r_op_pend  <= d_op_pend;
                r_op2_pend <= d_op2_pend;
                r_del_pend <= d_del;
                if (d_fill_inc) r_fill <= r_fill + FILL_W'(1);
            end
            if (i_cmd.lv_wr) begin
                r_op_pend  <= r_op2_pend;
                r_op2_pend <= 1'b0;
                if (r_op.side) r_bsum[w_hi] <= |w_word;
                else r_asum[w_hi] <= |w_word;
            end
            if (i_cmd.mv_wr) begin
                r_del_pend <= 1'b0;
                r_fill     <= w_last;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.scan && r_rd_pend && r_slot_rd.key == r_item.id) begin
            r_s   <= r_rd_addr;
            r_ent <= r_slot_rd;
        end
        if (i_cmd.scan && r_rd_pend && r_slot_rd.key == r_item.new_id) r_o <= r_rd_addr;
        if (w_scan_go) r_rd_addr <= r_scan[SLOT_W-1:0];
        if (i_cmd.decide) begin
            r_status <= d_status;
            r_op     <= d_op;
            r_op2    <= d_op2;
        end
        if (i_cmd.lv_sub) begin
            if (w_lv.qty > QTY_W'(r_op.sub)) r_qsub <= w_lv.qty - QTY_W'(r_op.sub);
            else r_qsub <= '0;
        end
        if (i_cmd.lv_wr) r_op <= r_op2;
        if (i_cmd.srch) begin
            r_bhi  <= f_sum_hi(r_bsum);
            r_ahi  <= f_sum_lo(r_asum);
            r_bany <= |r_bsum;
            r_aany <= |r_asum;
        end
        if (i_cmd.senc) begin
            r_blo <= f_word_hi(r_bocc_rd);
            r_alo <= f_word_lo(r_aocc_rd);
        end
        if (i_cmd.sout) begin
            r_out_status <= r_status;
            r_out_bid    <= r_bany ? PRICE_W'({r_bhi, r_blo}) + r_base_price : '0;
            r_out_ask    <= r_aany ? PRICE_W'({r_ahi, r_alo}) + r_base_price : '0;
        end
    end

    assign o_sts.clr_done  = r_clr_done;
    assign o_sts.scan_done = (r_scan == r_fill) && !r_rd_pend;
    assign o_sts.op_pend   = r_op_pend;
    assign o_sts.del_pend  = r_del_pend;
    assign o_status        = r_out_status;
    assign o_best_bid      = r_out_bid;
    assign o_best_ask      = r_out_ask;

endmodule

// ----- sv/price_indexed_order_book_core.sv -----
// from input transfer to result valid a command passes the id scan, the decision, its level
// updates, a move of the last order table entry into any freed slot, and the best price search
// the id scan walks the order table one entry a cycle; each level update reads, subtracts,
// writes back and decides the next step; one command is in work at a time; a result not yet
// taken holds the next; reset is synchronous, afterwards a clearing pass zeroes the level arrays
// and no command is taken until it ends, configuration writes are taken throughout
module price_indexed_order_book_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // order_id, new_order_id, side, quantity, price, zero fill
    input  logic [piob_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // command
    input  logic [piob_pkg::CMD_W-1:0]           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // best_bid_price, best_ask_price
    output logic [piob_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // status
    output logic [piob_pkg::ST_W-1:0]            m_axis_tuser,
    input  logic                                 i_cfg_wr_en,
    input  logic [piob_pkg::PRICE_W-1:0]         i_cfg_wr_data
);
    import piob_pkg::*;

    t_cmd               w_cmd;
    t_sts               w_sts;
    t_item              w_item;
    logic [PRICE_W-1:0] w_bid, w_ask;

    assign w_item.cmd    = s_axis_tuser;
    assign w_item.id     = s_axis_tdata[ID_W-1:0];
    assign w_item.new_id = s_axis_tdata[2*ID_W-1:ID_W];
    assign w_item.side   = s_axis_tdata[2*ID_W];
    assign w_item.qty    = s_axis_tdata[2*ID_W+QTY_IN_W:2*ID_W+1];
    assign w_item.price  = s_axis_tdata[IN_FIELDS_W-1:2*ID_W+QTY_IN_W+1];

    piob_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    piob_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_item        (w_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_sts         (w_sts),
        .o_status      (m_axis_tuser),
        .o_best_bid    (w_bid),
        .o_best_ask    (w_ask)
    );

    assign m_axis_tdata = {w_ask, w_bid};

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("command taken while another is in work");

    a_no_cmd_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_sts.clr_done |-> !s_axis_tready)
        else $error("command taken during level clearing");

    a_result_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.sout))
        else $error("result raised without a finished search");
`endif

endmodule
